### design/qlrp_pkg.sv
// ----------------------------------------------------------------------------
// qlrp_pkg: shared types and constants of the queue load rebalance planner
// Fixed widths of the result fields, configuration constants, sequencer states.
// ----------------------------------------------------------------------------
package qlrp_pkg;

  // fixed result field widths
  localparam int unsigned OUT_IDX_W = 4;
  localparam int unsigned OUT_AMT_W = 20;
  localparam int unsigned OUT_TOT_W = 24;

  // active queue count register
  localparam int unsigned ACTIVE_W = 5;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_MOVE = 5'b01000,
    ST_SUM  = 5'b10000
  } state_e;

endpackage

### design/qlrp_mem.sv
// ----------------------------------------------------------------------------
// qlrp_mem: queue size store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module qlrp_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned DATA_W = 20,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/qlrp_div.sv
// ----------------------------------------------------------------------------
// qlrp_div: restoring divider
// One quotient bit per cycle while busy; busy from start until all DIVIDEND_W bits are done.
// ----------------------------------------------------------------------------
module qlrp_div #(
  parameter int unsigned DIVIDEND_W = 24,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  div_q;

  logic [DIVISOR_W:0] rem_sh;
  logic [DIVISOR_W:0] rem_sub;
  logic               ge;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
    ge      = (rem_sh >= {1'b0, div_q});
    rem_sub = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_sub[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

### design/queue_load_rebalance_planner_core.sv
// ----------------------------------------------------------------------------
// queue_load_rebalance_planner_core: plans item moves that level worker queues
// Loads queue counts, divides the total by the active queue count, then emits
// donor/receiver/amount moves and a closing summary request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one queue count per request,
//   in queue index order; last_queue_i marks the final count of a run. Counts are
//   accepted only while the block is loading.
//   On the last count the block stops accepting and plans the run:
//     - divide: the total runs through the restoring divider; unloaded queues
//       below the active count are zeroed meanwhile.
//     - each plan step: one scan of the active queues through the store read
//       port, then a commit of the move.
//   Output channel (out_valid_o/out_ready_i) delivers up to MAX_QUEUES-1 move
//   requests, then one summary request with last_result_o set. A one-entry
//   output register holds each request; a stalled receiver holds the planner in
//   the commit cycle, and loading of the next run proceeds while the summary
//   still waits to be taken.
//   cfg_we_i/cfg_wdata_i write the active queue count (reset value 16); users
//   must write only when idle (unchecked); reset clears control, not the store.
// ----------------------------------------------------------------------------
module queue_load_rebalance_planner_core #(
  parameter int unsigned MAX_QUEUES = 16,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [qlrp_pkg::ACTIVE_W-1:0]        cfg_wdata_i,
  // queue counts
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [COUNT_BITS-1:0]                queue_size_i,
  input  logic                                 last_queue_i,
  // move plan
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 move_valid_o,
  output logic [qlrp_pkg::OUT_IDX_W-1:0]       source_queue_o,
  output logic [qlrp_pkg::OUT_IDX_W-1:0]       target_queue_o,
  output logic [qlrp_pkg::OUT_AMT_W-1:0]       move_amount_o,
  output logic [qlrp_pkg::OUT_TOT_W-1:0]       total_items_o,
  output logic                                 last_result_o
);

  localparam int unsigned IDX_W = $clog2(MAX_QUEUES);
  localparam int unsigned NT_W  = $clog2(MAX_QUEUES + 1);
  localparam int unsigned TOT_W = COUNT_BITS + $clog2(MAX_QUEUES);
  // widths used to extend before trimming to the fixed result fields
  localparam int unsigned IX_W  = (IDX_W > qlrp_pkg::OUT_IDX_W) ? IDX_W : qlrp_pkg::OUT_IDX_W;
  localparam int unsigned AX_W  =
    (COUNT_BITS > qlrp_pkg::OUT_AMT_W) ? COUNT_BITS : qlrp_pkg::OUT_AMT_W;
  localparam int unsigned TX_W  = (TOT_W > qlrp_pkg::OUT_TOT_W) ? TOT_W : qlrp_pkg::OUT_TOT_W;

  qlrp_pkg::state_e state_q, state_d;

  logic [qlrp_pkg::ACTIVE_W-1:0] aq_q, aq_d;
  logic [NT_W-1:0]       load_idx_q, load_idx_d;
  logic [TOT_W-1:0]      total_q, total_d;
  logic [NT_W-1:0]       nt_q, nt_d;
  logic [TOT_W-1:0]      ave_q, ave_d;
  logic [TOT_W:0]        ave_p1_q, ave_p1_d;
  logic [NT_W-1:0]       fill_ptr_q, fill_ptr_d;
  logic [NT_W-1:0]       scan_ptr_q, scan_ptr_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  recv_vld_q, recv_vld_d;
  logic [IDX_W-1:0]      recv_idx_q, recv_idx_d;
  logic [COUNT_BITS-1:0] recv_val_q, recv_val_d;
  logic                  donor_vld_q, donor_vld_d;
  logic [IDX_W-1:0]      donor_idx_q, donor_idx_d;
  logic [COUNT_BITS-1:0] donor_val_q, donor_val_d;
  logic [NT_W-1:0]       step_q, step_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic                  out_load;
  logic                  out_move_d, out_move_q;
  logic [IDX_W-1:0]      out_src_d, out_src_q;
  logic [IDX_W-1:0]      out_dst_d, out_dst_q;
  logic [COUNT_BITS-1:0] out_amt_d, out_amt_q;
  logic [TOT_W-1:0]      out_tot_d, out_tot_q;

  // store port
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] mem_rdata;

  // divider
  logic                  div_start;
  logic [TOT_W-1:0]      div_dividend;
  logic                  div_busy;
  logic [TOT_W-1:0]      div_quo;

  logic                  in_acc;
  logic                  store_en;
  logic [NT_W-1:0]       nt_cfg;
  logic [TOT_W-1:0]      rd_ext;
  logic                  is_recv, is_donor;
  logic [TOT_W-1:0]      gap_r, gap_d;
  logic                  recv_small;
  logic [COUNT_BITS-1:0] amt;
  logic                  emit_ok;
  logic                  out_free;

  assign in_ready_o = (state_q == qlrp_pkg::ST_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  // counts beyond the store depth are dropped
  assign store_en   = in_acc && (load_idx_q < NT_W'(MAX_QUEUES));
  assign out_free   = !out_valid_q || out_ready_i;

  // divisor clamp: zero acts as one, above depth acts as depth
  always_comb begin
    if (aq_q == '0) begin
      nt_cfg = NT_W'(1);
    end else if (int'(aq_q) > MAX_QUEUES) begin
      nt_cfg = NT_W'(MAX_QUEUES);
    end else begin
      nt_cfg = NT_W'(aq_q);
    end
  end

  // scan compares and move arithmetic
  always_comb begin
    rd_ext     = TOT_W'(mem_rdata);
    is_recv    = rd_ext < ave_q;
    is_donor   = {1'b0, rd_ext} > ave_p1_q;
    gap_r      = ave_q - TOT_W'(recv_val_q);
    gap_d      = TOT_W'(donor_val_q) - ave_q;
    recv_small = gap_r < gap_d;
    amt        = recv_small ? gap_r[COUNT_BITS-1:0] : gap_d[COUNT_BITS-1:0];
    emit_ok    = step_q < NT_W'(MAX_QUEUES - 1);
  end

  assign div_dividend = store_en ? (total_q + TOT_W'(queue_size_i)) : total_q;
  assign div_start    = in_acc && last_queue_i;

  always_comb begin
    state_d     = state_q;
    aq_d        = cfg_we_i ? cfg_wdata_i : aq_q;
    load_idx_d  = load_idx_q;
    total_d     = total_q;
    nt_d        = nt_q;
    ave_d       = ave_q;
    ave_p1_d    = ave_p1_q;
    fill_ptr_d  = fill_ptr_q;
    scan_ptr_d  = scan_ptr_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    recv_vld_d  = recv_vld_q;
    recv_idx_d  = recv_idx_q;
    recv_val_d  = recv_val_q;
    donor_vld_d = donor_vld_q;
    donor_idx_d = donor_idx_q;
    donor_val_d = donor_val_q;
    step_d      = step_q;
    out_load    = 1'b0;
    out_move_d  = 1'b0;
    out_src_d   = '0;
    out_dst_d   = '0;
    out_amt_d   = '0;
    out_tot_d   = '0;
    mem_we      = 1'b0;
    mem_waddr   = load_idx_q[IDX_W-1:0];
    mem_wdata   = queue_size_i;

    unique case (state_q)
      qlrp_pkg::ST_LOAD: begin
        mem_we = store_en;
        if (store_en) begin
          load_idx_d = load_idx_q + NT_W'(1);
          total_d    = div_dividend;
        end
        if (div_start) begin
          nt_d        = nt_cfg;
          fill_ptr_d  = store_en ? (load_idx_q + NT_W'(1)) : load_idx_q;
          recv_vld_d  = 1'b0;
          donor_vld_d = 1'b0;
          step_d      = '0;
          state_d     = qlrp_pkg::ST_DIV;
        end
      end

      qlrp_pkg::ST_DIV: begin
        // unloaded active queues count as empty
        mem_waddr = fill_ptr_q[IDX_W-1:0];
        mem_wdata = '0;
        if (fill_ptr_q < nt_q) begin
          mem_we     = 1'b1;
          fill_ptr_d = fill_ptr_q + NT_W'(1);
        end else if (!div_busy) begin
          ave_d      = div_quo;
          ave_p1_d   = {1'b0, div_quo} + (TOT_W+1)'(1);
          scan_ptr_d = '0;
          state_d    = qlrp_pkg::ST_SCAN;
        end
      end

      qlrp_pkg::ST_SCAN: begin
        if (scan_ptr_q < nt_q) begin
          rd_vld_d   = 1'b1;
          rd_idx_d   = scan_ptr_q[IDX_W-1:0];
          scan_ptr_d = scan_ptr_q + NT_W'(1);
        end
        // lowest index wins for each open role
        if (rd_vld_q) begin
          if (!recv_vld_q && is_recv) begin
            recv_vld_d = 1'b1;
            recv_idx_d = rd_idx_q;
            recv_val_d = mem_rdata;
          end
          if (!donor_vld_q && is_donor) begin
            donor_vld_d = 1'b1;
            donor_idx_d = rd_idx_q;
            donor_val_d = mem_rdata;
          end
        end else if (scan_ptr_q == nt_q) begin
          if (step_q != NT_W'(MAX_QUEUES) && recv_vld_q && donor_vld_q) begin
            state_d = qlrp_pkg::ST_MOVE;
          end else begin
            state_d = qlrp_pkg::ST_SUM;
          end
        end
      end

      qlrp_pkg::ST_MOVE: begin
        mem_wdata = ave_q[COUNT_BITS-1:0];
        mem_waddr = recv_small ? recv_idx_q : donor_idx_q;
        if (!emit_ok || out_free) begin
          // the side with the smaller gap (donor on a tie) lands on target and is freed
          mem_we = 1'b1;
          if (recv_small) begin
            recv_vld_d  = 1'b0;
            donor_val_d = donor_val_q - amt;
          end else begin
            donor_vld_d = 1'b0;
            recv_val_d  = recv_val_q + amt;
          end
          out_load   = emit_ok;
          out_move_d = 1'b1;
          out_src_d  = donor_idx_q;
          out_dst_d  = recv_idx_q;
          out_amt_d  = amt;
          step_d     = step_q + NT_W'(1);
          scan_ptr_d = '0;
          state_d    = qlrp_pkg::ST_SCAN;
        end
      end

      qlrp_pkg::ST_SUM: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_tot_d   = total_q;
          load_idx_d  = '0;
          total_d     = '0;
          recv_vld_d  = 1'b0;
          donor_vld_d = 1'b0;
          state_d     = qlrp_pkg::ST_LOAD;
        end
      end

      default: begin
        state_d = qlrp_pkg::ST_LOAD;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qlrp_pkg::ST_LOAD;
      aq_q        <= qlrp_pkg::ACTIVE_RESET;
      load_idx_q  <= '0;
      total_q     <= '0;
      nt_q        <= '0;
      fill_ptr_q  <= '0;
      scan_ptr_q  <= '0;
      rd_vld_q    <= 1'b0;
      recv_vld_q  <= 1'b0;
      donor_vld_q <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      aq_q        <= aq_d;
      load_idx_q  <= load_idx_d;
      total_q     <= total_d;
      nt_q        <= nt_d;
      fill_ptr_q  <= fill_ptr_d;
      scan_ptr_q  <= scan_ptr_d;
      rd_vld_q    <= rd_vld_d;
      recv_vld_q  <= recv_vld_d;
      donor_vld_q <= donor_vld_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    ave_q       <= ave_d;
    ave_p1_q    <= ave_p1_d;
    rd_idx_q    <= rd_idx_d;
    recv_idx_q  <= recv_idx_d;
    recv_val_q  <= recv_val_d;
    donor_idx_q <= donor_idx_d;
    donor_val_q <= donor_val_d;
    if (out_load) begin
      out_move_q <= out_move_d;
      out_src_q  <= out_src_d;
      out_dst_q  <= out_dst_d;
      out_amt_q  <= out_amt_d;
      out_tot_q  <= out_tot_d;
    end
  end

  qlrp_mem #(
    .DEPTH  (MAX_QUEUES),
    .DATA_W (COUNT_BITS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (scan_ptr_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  qlrp_div #(
    .DIVIDEND_W (TOT_W),
    .DIVISOR_W  (NT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (nt_cfg),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // result fields at their fixed widths
  logic [IX_W-1:0] src_ext, dst_ext;
  logic [AX_W-1:0] amt_ext;
  logic [TX_W-1:0] tot_ext;

  assign src_ext = IX_W'(out_src_q);
  assign dst_ext = IX_W'(out_dst_q);
  assign amt_ext = AX_W'(out_amt_q);
  assign tot_ext = TX_W'(out_tot_q);

  assign out_valid_o    = out_valid_q;
  assign move_valid_o   = out_move_q;
  assign source_queue_o = src_ext[qlrp_pkg::OUT_IDX_W-1:0];
  assign target_queue_o = dst_ext[qlrp_pkg::OUT_IDX_W-1:0];
  assign move_amount_o  = amt_ext[qlrp_pkg::OUT_AMT_W-1:0];
  assign total_items_o  = tot_ext[qlrp_pkg::OUT_TOT_W-1:0];
  assign last_result_o  = !out_move_q;

endmodule
